### rtl/nts_pkg.sv
// Shared types, constants and helpers for the nearest texture scaler.
// No dependencies; used by the scaler top level and its port checker.

package nts_pkg;

    // Fixed field widths
    localparam int CFG_W    = 9;    // size registers
    localparam int CFG_IX_W = 3;    // register index on the config port
    localparam int PIX_W    = 8;    // palette index
    localparam int ADDR_W   = 16;   // source store address / destination index
    localparam int COORD_W  = 8;    // query row and column
    localparam int FRAC_SH  = 16;   // fraction bits of the SIDE_W.16 column step

    localparam int STORE_DEPTH = 1 << ADDR_W;

    // Default for the largest supported side
    localparam int MAX_SIDE_DEF = 256;

    // Reset value of every size register
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

    // Request types
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Register indexes
    localparam logic [CFG_IX_W-1:0] REG_SRC_W   = CFG_IX_W'(0);
    localparam logic [CFG_IX_W-1:0] REG_SRC_H   = CFG_IX_W'(1);
    localparam logic [CFG_IX_W-1:0] REG_TGT_W   = CFG_IX_W'(2);
    localparam logic [CFG_IX_W-1:0] REG_TGT_H   = CFG_IX_W'(3);
    localparam logic [CFG_IX_W-1:0] REG_BLK_COL = CFG_IX_W'(4);
    localparam logic [CFG_IX_W-1:0] REG_BLK_ROW = CFG_IX_W'(5);

    typedef logic [PIX_W-1:0] t_pix;

    // Palette index 0 and 255 trade places, all others pass
    function automatic t_pix swap_ends(input t_pix p);
        t_pix r;
        r = p;
        if (p == '1) begin
            r = '0;
        end else if (p == '0) begin
            r = '1;
        end
        return r;
    endfunction

endpackage

### rtl/nearest_texture_scaler.sv
// Nearest-neighbor texture scaler: source pixel store plus query sequencer.
// Depends on nts_pkg.

// Loads do not occupy the sequencer: the pixel is written into a 64K x 8
// synchronous store at the transfer edge and the block stays ready. A query
// returns one pixel and its destination index. An unwritten position passes
// states PREP and RESULT, a straight copy PREP, READ and RESULT, and a scaled
// sample PREP, DIV, COL, ADDR, READ and RESULT, where DIV runs the shared
// one-bit-per-cycle restoring divider that forms the source row. The first
// scaled query after any register write also computes the SIDE_W.16 column
// step on that divider first (SIDE_W = clog2(MAX_SIDE + 1)); the step is kept
// until the next register write. The finished result sits in an output
// register, so a new item is taken while the previous result waits.

module nearest_texture_scaler #(
    parameter int MAX_SIDE = nts_pkg::MAX_SIDE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [nts_pkg::CFG_IX_W-1:0] i_cfg_index,
    input  logic [nts_pkg::CFG_W-1:0]    i_cfg_data,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic [nts_pkg::ADDR_W-1:0]   i_load_index,
    input  logic [nts_pkg::PIX_W-1:0]    i_load_pixel,
    input  logic [nts_pkg::COORD_W-1:0]  i_query_row,
    input  logic [nts_pkg::COORD_W-1:0]  i_query_col,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [nts_pkg::PIX_W-1:0]    o_pixel_out,
    output logic [nts_pkg::ADDR_W-1:0]   o_dest_index,
    output logic                         o_is_written
);

    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int CMP_W   = (SIDE_W > nts_pkg::COORD_W) ? SIDE_W : nts_pkg::COORD_W;
    localparam int DEST_W  = nts_pkg::COORD_W + SIDE_W + 1;
    localparam int RP_W    = nts_pkg::COORD_W + SIDE_W;
    localparam int STEP_W  = SIDE_W + nts_pkg::FRAC_SH;
    localparam int FRAC_W  = STEP_W + nts_pkg::COORD_W + 1;
    localparam int SCOL_W  = FRAC_W - nts_pkg::FRAC_SH;
    localparam int ASUM_W  = ((2 * SIDE_W > SCOL_W) ? 2 * SIDE_W : SCOL_W) + 1;
    localparam int CNT_W   = $clog2(STEP_W + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_COL    = 3'd3;
    localparam logic [2:0] S_ADDR   = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    // Saturate a size register into 1..MAX_SIDE
    function automatic logic [SIDE_W-1:0] side_clamp(input logic [nts_pkg::CFG_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (32'(v) > MAX_SIDE) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = SIDE_W'(v);
        end
        return r;
    endfunction

    localparam logic [SIDE_W-1:0] SIDE_RESET = side_clamp(nts_pkg::CFG_RESET);

    // Control registers
    logic [2:0]        r_state, n_state;
    logic              r_step_ok, n_step_ok;
    logic              r_out_valid, n_out_valid;
    logic              r_div_step, n_div_step;
    logic [CNT_W-1:0]  r_div_cnt, n_div_cnt;
    // Clamped size registers
    logic [SIDE_W-1:0] r_sw, r_sh, r_tw, r_th, r_bw, r_bh;

    // Datapath registers
    logic [nts_pkg::COORD_W-1:0] r_row, r_col;
    logic [nts_pkg::ADDR_W-1:0]  r_dest;
    logic                        r_wr;
    logic [SIDE_W-1:0]           r_rem, r_den;
    logic [STEP_W-1:0]           r_div_q;
    logic [STEP_W-1:0]           r_step;
    logic [SIDE_W-1:0]           r_srow;
    logic [SCOL_W-1:0]           r_scol;
    logic [nts_pkg::ADDR_W-1:0]  r_addr;
    logic [nts_pkg::PIX_W-1:0]   r_rd_data;
    logic [nts_pkg::PIX_W-1:0]   r_pix_o;
    logic [nts_pkg::ADDR_W-1:0]  r_dest_o;
    logic                        r_wr_o;

    // Source pixel store
    logic [nts_pkg::PIX_W-1:0] mem [nts_pkg::STORE_DEPTH];

    // Handshakes; no transfer is taken while reset is held
    logic w_in_xfer, w_load_we, w_out_free;
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_load_we  = w_in_xfer && (i_req_type == nts_pkg::REQ_LOAD);
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall   = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_pix_o;
    assign o_dest_index = r_dest_o;
    assign o_is_written = r_wr_o;

    // Query classification
    logic w_copy, w_in_blk, w_in_tgt, w_wr;
    assign w_copy   = (r_sw == r_bw) && (r_sh == r_bh);
    assign w_in_blk = (CMP_W'(r_row) < CMP_W'(r_bh)) && (CMP_W'(r_col) < CMP_W'(r_bw));
    assign w_in_tgt = (CMP_W'(r_row) < CMP_W'(r_th)) && (CMP_W'(r_col) < CMP_W'(r_tw));
    assign w_wr     = w_in_blk && (w_copy || w_in_tgt);

    // Destination index, row-major in the block
    logic [DEST_W-1:0] w_dest_full;
    assign w_dest_full = DEST_W'(r_row) * DEST_W'(r_bw) + DEST_W'(r_col);

    // Dividend of the source-row division
    logic [RP_W-1:0] w_row_prod;
    assign w_row_prod = RP_W'(r_row) * RP_W'(r_sh);

    // One restoring divider step
    logic [SIDE_W:0]   w_try, w_sub;
    logic              w_ge;
    logic [SIDE_W-1:0] n_rem;
    logic [STEP_W-1:0] n_div_q;
    assign w_try   = {r_rem, r_div_q[STEP_W-1]};
    assign w_ge    = (w_try >= {1'b0, r_den});
    assign w_sub   = w_try - {1'b0, r_den};
    assign n_rem   = w_ge ? w_sub[SIDE_W-1:0] : w_try[SIDE_W-1:0];
    assign n_div_q = {r_div_q[STEP_W-2:0], w_ge};

    // Column position from the SIDE_W.16 step, started at half a step
    logic [FRAC_W-1:0] w_frac;
    logic [SCOL_W-1:0] w_scol;
    assign w_frac = (FRAC_W'(r_step) >> 1) + FRAC_W'(r_col) * FRAC_W'(r_step);
    assign w_scol = SCOL_W'(w_frac >> nts_pkg::FRAC_SH);

    // Source address of a scaled sample
    logic [ASUM_W-1:0] w_asum;
    assign w_asum = ASUM_W'(r_srow) * ASUM_W'(r_sw) + ASUM_W'(r_scol);

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_step_ok   = r_step_ok;
        n_div_step  = r_div_step;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer && (i_req_type == nts_pkg::REQ_QUERY)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (!w_wr) begin
                    n_state = S_RESULT;
                end else if (w_copy) begin
                    n_state = S_READ;
                end else begin
                    n_state    = S_DIV;
                    n_div_step = !r_step_ok;
                    n_div_cnt  = r_step_ok ? CNT_W'(SIDE_W) : CNT_W'(STEP_W);
                end
            end
            S_DIV: begin
                n_div_cnt = r_div_cnt - CNT_W'(1);
                if (r_div_cnt == CNT_W'(1)) begin
                    if (r_div_step) begin
                        // step ready, now the source row
                        n_step_ok  = 1'b1;
                        n_div_step = 1'b0;
                        n_div_cnt  = CNT_W'(SIDE_W);
                    end else begin
                        n_state = S_COL;
                    end
                end
            end
            S_COL:  n_state = S_ADDR;
            S_ADDR: n_state = S_READ;
            S_READ: n_state = S_RESULT;
            S_RESULT: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // any register write drops the cached column step
        if (i_cfg_we) begin
            n_step_ok = 1'b0;
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step_ok   <= 1'b0;
            r_out_valid <= 1'b0;
            r_div_step  <= 1'b0;
            r_div_cnt   <= '0;
            r_sw        <= SIDE_RESET;
            r_sh        <= SIDE_RESET;
            r_tw        <= SIDE_RESET;
            r_th        <= SIDE_RESET;
            r_bw        <= SIDE_RESET;
            r_bh        <= SIDE_RESET;
        end else begin
            r_state     <= n_state;
            r_step_ok   <= n_step_ok;
            r_out_valid <= n_out_valid;
            r_div_step  <= n_div_step;
            r_div_cnt   <= n_div_cnt;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    nts_pkg::REG_SRC_W:   r_sw <= side_clamp(i_cfg_data);
                    nts_pkg::REG_SRC_H:   r_sh <= side_clamp(i_cfg_data);
                    nts_pkg::REG_TGT_W:   r_tw <= side_clamp(i_cfg_data);
                    nts_pkg::REG_TGT_H:   r_th <= side_clamp(i_cfg_data);
                    nts_pkg::REG_BLK_COL: r_bw <= side_clamp(i_cfg_data);
                    nts_pkg::REG_BLK_ROW: r_bh <= side_clamp(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        // capture query coordinates
        if (w_in_xfer) begin
            r_row <= i_query_row;
            r_col <= i_query_col;
        end

        // classify, form destination, start divider
        if (r_state == S_PREP) begin
            r_dest <= nts_pkg::ADDR_W'(w_dest_full);
            r_wr   <= w_wr;
            r_addr <= nts_pkg::ADDR_W'(w_dest_full);
            if (r_step_ok) begin
                r_rem   <= SIDE_W'(w_row_prod >> SIDE_W);
                r_div_q <= {w_row_prod[SIDE_W-1:0], nts_pkg::FRAC_SH'(0)};
                r_den   <= r_th;
            end else begin
                r_rem   <= '0;
                r_div_q <= {r_sw, nts_pkg::FRAC_SH'(0)};
                r_den   <= r_tw;
            end
        end

        // divider iterations
        if (r_state == S_DIV) begin
            r_rem   <= n_rem;
            r_div_q <= n_div_q;
            if (r_div_cnt == CNT_W'(1)) begin
                if (r_div_step) begin
                    r_step  <= n_div_q;
                    r_rem   <= SIDE_W'(w_row_prod >> SIDE_W);
                    r_div_q <= {w_row_prod[SIDE_W-1:0], nts_pkg::FRAC_SH'(0)};
                    r_den   <= r_th;
                end else begin
                    r_srow <= n_div_q[SIDE_W-1:0];
                end
            end
        end

        if (r_state == S_COL) begin
            r_scol <= w_scol;
        end

        if (r_state == S_ADDR) begin
            r_addr <= nts_pkg::ADDR_W'(w_asum);
        end

        // result register
        if ((r_state == S_RESULT) && w_out_free) begin
            r_pix_o  <= r_wr ? nts_pkg::swap_ends(r_rd_data) : '0;
            r_dest_o <= r_dest;
            r_wr_o   <= r_wr;
        end
    end

    // Store write port: loads
    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            mem[i_load_index] <= i_load_pixel;
        end
    end

    // Store read port, registered in S_READ
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_data <= mem[r_addr];
        end
    end

endmodule

### rtl/nts_checker.sv
// Port-level checker for the nearest texture scaler, bound to the top level.
// Depends on nts_pkg.

module nts_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_we,
    input logic [nts_pkg::CFG_IX_W-1:0] i_cfg_index,
    input logic [nts_pkg::CFG_W-1:0]    i_cfg_data,
    input logic                         i_in_valid,
    input logic                         o_in_stall,
    input logic                         i_req_type,
    input logic [nts_pkg::ADDR_W-1:0]   i_load_index,
    input logic [nts_pkg::PIX_W-1:0]    i_load_pixel,
    input logic [nts_pkg::COORD_W-1:0]  i_query_row,
    input logic [nts_pkg::COORD_W-1:0]  i_query_col,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [nts_pkg::PIX_W-1:0]    o_pixel_out,
    input logic [nts_pkg::ADDR_W-1:0]   o_dest_index,
    input logic                         o_is_written
);

    logic w_in_xfer;
    assign w_in_xfer = i_in_valid && !o_in_stall;

    // Result channel comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_pixel_out) && $stable(o_dest_index)
            && $stable(o_is_written))
        else $error("stalled result changed");

    // A position that is not written reports pixel zero
    a_unwritten_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_written |-> o_pixel_out == '0)
        else $error("unwritten position with nonzero pixel");

    // A load never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && (i_req_type == nts_pkg::REQ_LOAD) |=> !$rose(o_out_valid))
        else $error("result appeared after a load");

    // A query occupies the block in the following cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && (i_req_type == nts_pkg::REQ_QUERY) |=> o_in_stall)
        else $error("block ready right after a query transfer");

endmodule

bind nearest_texture_scaler nts_checker u_nts_checker (.*);
